FILE: rtl/tgrj_pkg.sv
// shared constants and helpers for the two-gaussian residual and jacobian block
package tgrj_pkg;

  localparam int RQ_W      = 20;  // ratio quotient bits, saturates at 8.0
  localparam int DQ_W      = 32;  // derivative quotient bits before saturation
  localparam int GAUSS_LAT = 19;

  localparam logic [RQ_W-1:0] RATIO_MAX = RQ_W'(8 * 65536);
  localparam logic [30:0]     Q30_ONE   = 31'd1073741824;
  localparam logic [29:0]     LN2_Q30   = 30'd744261118;
  localparam logic [30:0]     LOG2E_Q30 = 31'd1549082005;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MEAN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_AMPLITUDE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SIGMA     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_AMPLITUDE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_OFFSET    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_FACTOR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL_ONLY  = 3'd6;

  // exact floor(x / k) for x below 2^31 as (x * recip_mul(k)) >> recip_shift(k)
  function automatic logic [31:0] recip_mul(input int k);
    case (k)
      3:       recip_mul = 32'd2863311531;
      5:       recip_mul = 32'd3435973837;
      6:       recip_mul = 32'd2863311531;
      7:       recip_mul = 32'd2454267027;
      default: recip_mul = 32'd2147483648;
    endcase
  endfunction

  function automatic logic [5:0] recip_shift(input int k);
    case (k)
      1:       recip_shift = 6'd31;
      2:       recip_shift = 6'd32;
      3:       recip_shift = 6'd33;
      4:       recip_shift = 6'd33;
      default: recip_shift = 6'd34;
    endcase
  endfunction

endpackage

FILE: rtl/tgrj_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
module tgrj_div #(
  parameter int NW = 49,
  parameter int DW = 31,
  parameter int QW = 20
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] numer,
  input  logic [DW-1:0] denom,
  output logic [QW-1:0] quot,
  output logic          ovf
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic          ovf_r  [QW];
  logic [NW-1:0] rem_nx [QW];
  logic [QW-1:0] quo_nx [QW];
  logic [DW-1:0] den_nx [QW];
  logic          ovf_nx [QW];

  logic [CW-1:0] rin;
  logic [CW-1:0] sub;
  logic [QW-1:0] qin;

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        rin       = CW'(numer);
        qin       = '0;
        den_nx[j] = denom;
        ovf_nx[j] = (CW'(numer) >= (CW'(denom) << QW));
      end else begin
        rin       = CW'(rem_r[j-1]);
        qin       = quo_r[j-1];
        den_nx[j] = den_r[j-1];
        ovf_nx[j] = ovf_r[j-1];
      end
      sub = CW'(den_nx[j]) << (QW - 1 - j);
      if (rin >= sub) begin
        rem_nx[j] = NW'(rin - sub);
        quo_nx[j] = qin | (QW'(1) << (QW - 1 - j));
      end else begin
        rem_nx[j] = NW'(rin);
        quo_nx[j] = qin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < QW; j++) begin
        rem_r[j] <= rem_nx[j];
        quo_r[j] <= quo_nx[j];
        den_r[j] <= den_nx[j];
        ovf_r[j] <= ovf_nx[j];
      end
    end
  end

  assign quot = quo_r[QW-1];
  assign ovf  = ovf_r[QW-1];

endmodule

FILE: rtl/tgrj_exp.sv
// pipelined gaussian exp(-q^2/2), q4.16 in and q1.16 out, horner series over registered stages
module tgrj_exp (
  input  logic                     clk,
  input  logic                     en,
  input  logic [tgrj_pkg::RQ_W-1:0] q,
  output logic [16:0]              e
);
  import tgrj_pkg::*;

  localparam int NK = 7;

  logic [2*RQ_W-1:0] sq_r;
  logic [53:0]       tp_r;
  logic [45:0]       vp_r;
  logic [7:0]        n3_r;
  logic [29:0]       v4_r;
  logic [7:0]        n4_r;

  logic [60:0] pv_r  [NK];
  logic [62:0] rm_r  [NK];
  logic [29:0] va_r  [NK];
  logic [29:0] vb_r  [NK];
  logic [7:0]  na_r  [NK];
  logic [7:0]  nb_r  [NK];
  logic [30:0] p_in  [NK];
  logic [29:0] v_in  [NK];
  logic [7:0]  n_in  [NK];

  logic [23:0] t;
  logic [30:0] p_fin;
  logic [7:0]  sh;
  logic [16:0] e_nx;

  assign t = tp_r[53:30];

  always_comb begin
    for (int j = 0; j < NK; j++) begin
      if (j == 0) begin
        p_in[j] = Q30_ONE;
        v_in[j] = v4_r;
        n_in[j] = n4_r;
      end else begin
        p_in[j] = Q30_ONE - 31'(rm_r[j-1] >> recip_shift(NK + 1 - j));
        v_in[j] = vb_r[j-1];
        n_in[j] = nb_r[j-1];
      end
    end
    p_fin = Q30_ONE - 31'(rm_r[NK-1] >> recip_shift(1));
    sh    = nb_r[NK-1] + 8'd14;
    if (sh >= 8'd32) begin
      e_nx = '0;
    end else begin
      e_nx = 17'((33'(p_fin) + (33'(1) << (sh - 8'd1))) >> sh);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= q * q;
      tp_r <= 23'(sq_r >> 17) * LOG2E_Q30;
      vp_r <= t[15:0] * LN2_Q30;
      n3_r <= t[23:16];
      v4_r <= vp_r[45:16];
      n4_r <= n3_r;
      for (int j = 0; j < NK; j++) begin
        pv_r[j] <= v_in[j] * p_in[j];
        va_r[j] <= v_in[j];
        na_r[j] <= n_in[j];
        rm_r[j] <= pv_r[j][60:30] * recip_mul(NK - j);
        vb_r[j] <= va_r[j];
        nb_r[j] <= na_r[j];
      end
      e <= e_nx;
    end
  end

endmodule

FILE: rtl/two_gaussian_residual_jacobian.sv
// top level: two-gaussian model residual and jacobian, fully pipelined
// Takes one sample per clock while no finished result is stalled and gives one result
// per sample; it holds the four bit-per-stage dividers (20 stages for the distances
// in sigma units, 32 for the mean and sigma derivatives) and the 19-stage
// exponential with its seven-term series. The whole pipeline advances together and
// holds while a finished result is stalled, so sample_stall follows result_stall only
// when the output register is full. Configuration writes are always taken
// (cfg_ready is high) and must only be made while no item is in flight.
module two_gaussian_residual_jacobian (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic signed [31:0]                sample_pos,
  input  logic signed [31:0]                observed_count,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [31:0]                residual,
  output logic signed [31:0]                deriv_mean,
  output logic signed [31:0]                deriv_zero_amplitude,
  output logic signed [31:0]                deriv_sigma,
  output logic signed [31:0]                deriv_one_amplitude,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tgrj_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);
  import tgrj_pkg::*;

  localparam int S_IN   = 1;
  localparam int S_PREP = 2;
  localparam int S_DIV  = S_PREP + 1;
  localparam int S_Q    = S_DIV + RQ_W;
  localparam int S_E    = S_Q + GAUSS_LAT;
  localparam int S_T    = S_E + 1;
  localparam int S_RES  = S_T + 1;
  localparam int S_MQQ  = S_RES + 1;
  localparam int S_D    = S_MQQ + DQ_W;
  localparam int LAT    = S_D + 1;

  function automatic logic [31:0] sat35(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      sat35 = 32'h7FFFFFFF;
    end else if (v < -35'sd2147483648) begin
      sat35 = 32'h80000000;
    end else begin
      sat35 = v[31:0];
    end
  endfunction

  function automatic logic [31:0] sat_mag(input logic [31:0] m, input logic big,
                                          input logic neg);
    if (neg) begin
      sat_mag = (big || (m > 32'h80000000)) ? 32'h80000000 : -m;
    end else begin
      sat_mag = (big || m[31]) ? 32'h7FFFFFFF : m;
    end
  endfunction

  // configuration
  logic signed [31:0] zero_mean;
  logic signed [31:0] zero_amplitude;
  logic [30:0]        zero_sigma;
  logic signed [31:0] one_amplitude;
  logic signed [31:0] gain_offset;
  logic [30:0]        width_factor;
  logic               residual_only;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_mean      <= '0;
      zero_amplitude <= 32'sd65536;
      zero_sigma     <= 31'd65536;
      one_amplitude  <= 32'sd65536;
      gain_offset    <= 32'sd65536;
      width_factor   <= 31'd65536;
      residual_only  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ZERO_MEAN:      zero_mean      <= cfg_data;
        REG_ZERO_AMPLITUDE: zero_amplitude <= cfg_data;
        REG_ZERO_SIGMA:     zero_sigma     <= cfg_data[30:0];
        REG_ONE_AMPLITUDE:  one_amplitude  <= cfg_data;
        REG_GAIN_OFFSET:    gain_offset    <= cfg_data;
        REG_WIDTH_FACTOR:   width_factor   <= cfg_data[30:0];
        REG_RESIDUAL_ONLY:  residual_only  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [30:0] s0;
  logic [31:0] go_mag;
  logic [31:0] a0_mag;
  logic [31:0] a1_mag;

  assign s0     = (zero_sigma == '0) ? 31'd1 : zero_sigma;
  assign go_mag = gain_offset[31] ? 32'(-gain_offset) : 32'(gain_offset);
  assign a0_mag = zero_amplitude[31] ? 32'(-zero_amplitude) : 32'(zero_amplitude);
  assign a1_mag = one_amplitude[31] ? 32'(-one_amplitude) : 32'(one_amplitude);

  // pipeline control
  logic vld [1:LAT];
  logic en;

  assign en           = !(vld[LAT] && result_stall);
  assign sample_stall = vld[LAT] && result_stall;
  assign result_valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= LAT; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[1] <= sample_valid;
      for (int s = 2; s <= LAT; s++) vld[s] <= vld[s-1];
    end
  end

  // datapath registers
  logic signed [31:0] x_r;
  logic signed [31:0] y_p      [S_IN:S_T];
  logic signed [33:0] d0_r;
  logic [62:0]        go_prod_r;
  logic               go_neg_r;
  logic [61:0]        wf_prod_r;
  logic [48:0]        num0_r;
  logic [63:0]        num1_r;
  logic [46:0]        s1_r;
  logic               d0neg_p  [S_DIV:S_T];

  logic [46:0]        off_mag;
  logic signed [48:0] off_s;
  logic signed [48:0] d1;
  logic [32:0]        d0_mag;
  logic [47:0]        d1_mag;
  logic [46:0]        s1_full;

  assign d0_mag  = 33'(d0_r[33] ? -d0_r : d0_r);
  assign off_mag = 47'((go_prod_r + 63'h8000) >> 16);
  assign off_s   = go_neg_r ? -$signed({2'b00, off_mag}) : $signed({2'b00, off_mag});
  assign d1      = 49'(d0_r) - off_s;
  assign d1_mag  = 48'(d1[48] ? -d1 : d1);
  assign s1_full = 47'((wf_prod_r + 62'h8000) >> 16);

  // ratio dividers
  logic [RQ_W-1:0] quo0;
  logic [RQ_W-1:0] quo1;
  logic            ovf0;
  logic            ovf1;
  logic [RQ_W-1:0] q0c;
  logic [RQ_W-1:0] q1c;

  tgrj_div #(.NW(49), .DW(31), .QW(RQ_W)) u_div_q0 (
    .clk(clk), .en(en), .numer(num0_r), .denom(s0), .quot(quo0), .ovf(ovf0)
  );

  tgrj_div #(.NW(64), .DW(47), .QW(RQ_W)) u_div_q1 (
    .clk(clk), .en(en), .numer(num1_r), .denom(s1_r), .quot(quo1), .ovf(ovf1)
  );

  assign q0c = (ovf0 || quo0 > RATIO_MAX) ? RATIO_MAX : quo0;
  assign q1c = (ovf1 || quo1 > RATIO_MAX) ? RATIO_MAX : quo1;

  // exponentials
  logic [16:0] e0;
  logic [16:0] e1;

  tgrj_exp u_exp0 (.clk(clk), .en(en), .q(q0c), .e(e0));
  tgrj_exp u_exp1 (.clk(clk), .en(en), .q(q1c), .e(e1));

  logic [RQ_W-1:0] q0_p  [S_Q+1:S_RES];
  logic [16:0]     e0_p  [S_E+1:S_D];
  logic [16:0]     e1_p  [S_E+1:S_D];

  // model terms
  logic [48:0]        t0p_r;
  logic [48:0]        t1p_r;
  logic [31:0]        t0m;
  logic [31:0]        t1m;
  logic               t0neg;
  logic               t1neg;
  logic signed [33:0] t0s;
  logic signed [33:0] t1s;
  logic signed [34:0] sum;

  assign t0m   = 32'((t0p_r + 49'h8000) >> 16);
  assign t1m   = 32'((t1p_r + 49'h8000) >> 16);
  assign t0neg = zero_amplitude[31] && (t0m != '0);
  assign t1neg = one_amplitude[31] && (t1m != '0);
  assign t0s   = t0neg ? -$signed({2'b00, t0m}) : $signed({2'b00, t0m});
  assign t1s   = t1neg ? -$signed({2'b00, t1m}) : $signed({2'b00, t1m});
  assign sum   = 35'(t0s) + 35'(t1s) - 35'(y_p[S_T]);

  logic [31:0] res_p   [S_RES:S_D];
  logic        negm_p  [S_RES:S_D];
  logic        negs_p  [S_RES:S_D];
  logic [51:0] mq_r;
  logic [51:0] mq_p;
  logic [55:0] mqq_r;

  // derivative dividers
  logic [DQ_W-1:0] quo_m;
  logic [DQ_W-1:0] quo_s;
  logic            ovf_m;
  logic            ovf_s;

  tgrj_div #(.NW(52), .DW(31), .QW(DQ_W)) u_div_mean (
    .clk(clk), .en(en), .numer(mq_p), .denom(s0), .quot(quo_m), .ovf(ovf_m)
  );

  tgrj_div #(.NW(56), .DW(31), .QW(DQ_W)) u_div_sigma (
    .clk(clk), .en(en), .numer(mqq_r), .denom(s0), .quot(quo_s), .ovf(ovf_s)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      x_r        <= sample_pos;
      y_p[S_IN]  <= observed_count;
      for (int s = S_IN + 1; s <= S_T; s++) y_p[s] <= y_p[s-1];

      d0_r      <= 34'(x_r) - 34'(zero_mean);
      go_prod_r <= s0 * go_mag;
      go_neg_r  <= gain_offset[31];
      wf_prod_r <= s0 * width_factor;

      num0_r         <= {d0_mag, 16'h0000};
      num1_r         <= {d1_mag, 16'h0000};
      s1_r           <= (s1_full == '0) ? 47'd1 : s1_full;
      d0neg_p[S_DIV] <= d0_r[33];
      for (int s = S_DIV + 1; s <= S_T; s++) d0neg_p[s] <= d0neg_p[s-1];

      q0_p[S_Q+1] <= q0c;
      for (int s = S_Q + 2; s <= S_RES; s++) q0_p[s] <= q0_p[s-1];

      e0_p[S_E+1] <= e0;
      e1_p[S_E+1] <= e1;
      for (int s = S_E + 2; s <= S_D; s++) begin
        e0_p[s] <= e0_p[s-1];
        e1_p[s] <= e1_p[s-1];
      end

      t0p_r <= a0_mag * e0;
      t1p_r <= a1_mag * e1;

      res_p[S_RES]  <= sat35(sum);
      negm_p[S_RES] <= t0neg ^ d0neg_p[S_T];
      negs_p[S_RES] <= t0neg;
      mq_r          <= t0m * q0_p[S_T];
      for (int s = S_RES + 1; s <= S_D; s++) begin
        res_p[s]  <= res_p[s-1];
        negm_p[s] <= negm_p[s-1];
        negs_p[s] <= negs_p[s-1];
      end

      mq_p  <= mq_r;
      mqq_r <= mq_r[51:16] * q0_p[S_RES];

      residual <= res_p[S_D];
      if (residual_only) begin
        deriv_mean           <= '0;
        deriv_zero_amplitude <= '0;
        deriv_sigma          <= '0;
        deriv_one_amplitude  <= '0;
      end else begin
        deriv_mean           <= sat_mag(quo_m, ovf_m, negm_p[S_D]);
        deriv_zero_amplitude <= {15'h0000, e0_p[S_D]};
        deriv_sigma          <= sat_mag(quo_s, ovf_s, negs_p[S_D]);
        deriv_one_amplitude  <= {15'h0000, e1_p[S_D]};
      end
    end
  end

endmodule

FILE: bench/tb_two_gaussian_residual_jacobian.sv
// testbench for the two-gaussian residual and jacobian block
`timescale 1ns / 100ps

module tb_two_gaussian_residual_jacobian;
  import tgrj_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint unsigned ONE_Q30  = 64'd1073741824;
  localparam longint unsigned LN2_K    = 64'd744261118;
  localparam longint unsigned LOG2E_K  = 64'd1549082005;
  localparam longint unsigned DIST_CAP = 64'd524288;
  localparam int FLUSH_CYCLES = 120;

  typedef struct packed {
    logic signed [31:0] residual;
    logic signed [31:0] dmean;
    logic signed [31:0] dzamp;
    logic signed [31:0] dsig;
    logic signed [31:0] doamp;
  } fit_result_t;

  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] obs;
    bit                 known;
    logic signed [31:0] res;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst;
  logic sample_valid, sample_stall;
  logic signed [31:0] sample_pos, observed_count;
  logic result_valid, result_stall;
  logic signed [31:0] residual, deriv_mean, deriv_zero_amplitude, deriv_sigma;
  logic signed [31:0] deriv_one_amplitude;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  // shadow of the fit parameters
  logic signed [31:0] p_mean, p_amp0, p_amp1, p_gain;
  logic [30:0] p_sigma, p_width;
  logic p_resonly;

  fit_result_t pending_q[$];
  int fails = 0;
  int results_seen = 0;
  bit idle_on = 1'b1;

  two_gaussian_residual_jacobian dut (.*);

  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("two_gaussian_residual_jacobian verification failed");
    $finish;
  end

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint signed_of(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint unsigned m;
    m = (magn(a) * magn(b) + 64'h8000) >> 16;
    return signed_of(m, (a < 0) != (b < 0));
  endfunction

  function automatic longint unsigned dist_units(longint unsigned m, longint unsigned s);
    longint unsigned q;
    q = (m << 16) / s;
    return q > DIST_CAP ? DIST_CAP : q;
  endfunction

  function automatic longint unsigned gauss_exp(longint unsigned q);
    longint unsigned a, t, n, v, p;
    a = (q * q) >> 17;
    t = (a * LOG2E_K) >> 30;
    n = t >> 16;
    v = ((t & 64'hFFFF) * LN2_K) >> 16;
    p = ONE_Q30;
    for (int k = 7; k >= 1; k--) p = ONE_Q30 - ((v * p) >> 30) / longint'(k);
    return (p + (64'd1 << (13 + n))) >> (14 + n);
  endfunction

  function automatic fit_result_t model_fit(logic signed [31:0] pos, logic signed [31:0] obs);
    fit_result_t r;
    longint x, y, d0, d1, t0, t1;
    longint unsigned s0, s1, q0, q1, e0, e1, mt;
    x = pos;
    y = obs;
    s0 = (p_sigma != 0) ? longint'(p_sigma) : 64'd1;
    d0 = x - longint'(p_mean);
    q0 = dist_units(magn(d0), s0);
    e0 = gauss_exp(q0);
    t0 = qmul(longint'(p_amp0), longint'(e0));
    d1 = x - (longint'(p_mean) + qmul(longint'(s0), longint'(p_gain)));
    s1 = (s0 * longint'(p_width) + 64'h8000) >> 16;
    if (s1 == 0) s1 = 1;
    q1 = dist_units(magn(d1), s1);
    e1 = gauss_exp(q1);
    t1 = qmul(longint'(p_amp1), longint'(e1));
    r = '0;
    r.residual = clamp32(t0 + t1 - y);
    if (!p_resonly) begin
      mt = magn(t0);
      r.dmean = clamp32(signed_of((mt * q0) / s0, (t0 < 0) != (d0 < 0)));
      r.dzamp = e0[31:0];
      r.dsig  = clamp32(signed_of((((mt * q0) >> 16) * q0) / s0, t0 < 0));
      r.doamp = e1[31:0];
    end
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ZERO_MEAN:      p_mean    = val;
      REG_ZERO_AMPLITUDE: p_amp0    = val;
      REG_ZERO_SIGMA:     p_sigma   = val[30:0];
      REG_ONE_AMPLITUDE:  p_amp1    = val;
      REG_GAIN_OFFSET:    p_gain    = val;
      REG_WIDTH_FACTOR:   p_width   = val[30:0];
      REG_RESIDUAL_ONLY:  p_resonly = val[0];
      default: ;
    endcase
  endtask

  task automatic set_params(logic [31:0] m, logic [31:0] a0, logic [31:0] s,
                            logic [31:0] a1, logic [31:0] g, logic [31:0] w, bit obj);
    sample_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
    write_reg(REG_ZERO_MEAN, m);
    write_reg(REG_ZERO_AMPLITUDE, a0);
    write_reg(REG_ZERO_SIGMA, s);
    write_reg(REG_ONE_AMPLITUDE, a1);
    write_reg(REG_GAIN_OFFSET, g);
    write_reg(REG_WIDTH_FACTOR, w);
    write_reg(REG_RESIDUAL_ONLY, {31'd0, obj});
    write_reg(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic int srand(int range);
    return int'($urandom_range(0, 2 * range)) - range;
  endfunction

  task automatic send_item(logic signed [31:0] pos, logic signed [31:0] obs,
                           bit known, fit_result_t exp_r);
    int gap;
    sample_valid   <= 1'b1;
    sample_pos     <= pos;
    observed_count <= obs;
    do @(posedge clk); while (sample_stall);
    pending_q.push_back(known ? exp_r : model_fit(pos, obs));
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_items(int n);
    logic signed [31:0] pos;
    longint unsigned sg;
    for (int i = 0; i < n; i++) begin
      sg = (p_sigma != 0) ? longint'(p_sigma) : 64'd1;
      case ($urandom_range(0, 3))
        0: pos = $urandom;
        1: pos = 32'(p_mean + ((longint'(srand(6 * 65536)) * longint'(sg)) >>> 16));
        2: pos = 32'(p_mean + qmul(longint'(sg), longint'(p_gain))
                 + ((longint'(srand(6 * 65536)) * longint'(sg)) >>> 16));
        default: pos = p_mean + srand(3 * 65536);
      endcase
      send_item(pos, ($urandom_range(0, 1)) ? $urandom : srand(2000 * 65536), 1'b0, '0);
    end
  endtask

  // stall pattern and result check
  initial begin
    int hold;
    bit pressed;
    fit_result_t e;
    hold = 0;
    pressed = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_valid && !result_stall) begin
        results_seen++;
        if (pending_q.size() == 0) begin
          $error("result with nothing pending");
          fails++;
        end else begin
          e = pending_q.pop_front();
          if (residual !== e.residual) begin
            $error("residual exp %0d got %0d", e.residual, residual); fails++;
          end
          if (deriv_mean !== e.dmean) begin
            $error("deriv_mean exp %0d got %0d", e.dmean, deriv_mean); fails++;
          end
          if (deriv_zero_amplitude !== e.dzamp) begin
            $error("deriv_zero_amplitude exp %0d got %0d", e.dzamp, deriv_zero_amplitude);
            fails++;
          end
          if (deriv_sigma !== e.dsig) begin
            $error("deriv_sigma exp %0d got %0d", e.dsig, deriv_sigma); fails++;
          end
          if (deriv_one_amplitude !== e.doamp) begin
            $error("deriv_one_amplitude exp %0d got %0d", e.doamp, deriv_one_amplitude);
            fails++;
          end
        end
      end
      if (!pressed && results_seen >= 200) begin
        pressed = 1'b1;
        hold = 300;
      end else if (hold == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end
      if (hold > 0) begin
        hold--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    sample_row_t rows[$];
    fit_result_t e;
    rst <= 1'b1;
    sample_valid <= 1'b0;
    sample_pos <= '0;
    observed_count <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    p_mean = 0; p_amp0 = 65536; p_sigma = 65536; p_amp1 = 65536;
    p_gain = 65536; p_width = 65536; p_resonly = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // far rows have both exponentials at zero, so the result is just -obs, saturated to 32 bits
    rows = '{
      '{32'sh7fffffff, 32'sd0, 1'b1, 32'sd0},
      '{32'sh7fffffff, 32'sh7fffffff, 1'b1, -32'sh7fffffff},
      '{32'sh80000000, 32'sh80000000, 1'b1, 32'sh7fffffff},
      '{32'sh80000000, 32'sd1, 1'b1, -32'sd1},
      '{32'sh80000000, 32'sh7fffffff, 1'b1, 32'sh80000001},
      '{32'sd0, 32'sd0, 1'b0, 0},
      '{32'sd0, 32'sh7fffffff, 1'b0, 0},
      '{32'sd0, 32'sh80000000, 1'b0, 0},
      '{32'sd65536, 32'sd0, 1'b0, 0},
      '{-32'sd65536, 32'sd100, 1'b0, 0},
      '{32'sd32768, 32'sd12345, 1'b0, 0},
      '{32'sd131072, -32'sd5, 1'b0, 0},
      '{-32'sd131072, 32'sd65536, 1'b0, 0},
      '{32'sd196608, 32'sd0, 1'b0, 0},
      '{32'sd524288, 32'sd0, 1'b0, 0},
      '{32'sd600000, 32'sd0, 1'b0, 0},
      '{-32'sd600000, 32'sd0, 1'b0, 0},
      '{32'sd1, -32'sd1, 1'b0, 0},
      '{-32'sd1, 32'sd1, 1'b0, 0}
    };
    foreach (rows[i]) begin
      e = '0;
      e.residual = rows[i].res;
      send_item(rows[i].pos, rows[i].obs, rows[i].known, e);
    end

    set_params(srand(100 * 65536), srand(1000 * 65536), $urandom_range(1 << 12, 1 << 20),
               srand(1000 * 65536), srand(8 * 65536), $urandom_range(1 << 14, 4 << 16),
               1'b0);
    random_items(160);
    // zero width and zero one-photon width
    set_params(srand(1000), srand(1000 * 65536), 0, srand(1000 * 65536),
               srand(4 * 65536), 0, 1'b0);
    random_items(160);
    set_params(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
               32'h7fffffff, 32'h7fffffff, 1'b0);
    random_items(160);
    set_params(32'h80000000, 32'h80000000, 1, 32'h7fffffff, 32'h80000000, 1, 1'b1);
    random_items(160);
    set_params(srand(50 * 65536), 32'h7fffffff, $urandom_range(1 << 10, 1 << 17),
               32'h80000000, srand(8 * 65536), $urandom_range(1 << 15, 2 << 16), 1'b0);
    random_items(160);
    idle_on = 1'b0;
    set_params(srand(100 * 65536), srand(30000 * 65536), $urandom_range(1 << 8, 1 << 22),
               srand(30000 * 65536), srand(16 * 65536), $urandom_range(1, 8 << 16), 1'b0);
    random_items(160);
    idle_on = 1'b1;
    set_params(srand(100 * 65536), srand(1000 * 65536), $urandom_range(1 << 12, 1 << 20),
               srand(1000 * 65536), srand(8 * 65536), $urandom_range(1 << 14, 4 << 16),
               1'b1);
    random_items(160);

    sample_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("two_gaussian_residual_jacobian verification clean");
    end else begin
      $display("two_gaussian_residual_jacobian verification failed");
    end
    $finish;
  end

endmodule
